### rtl/hst_pkg.sv
`default_nettype none

package hst_pkg;

    localparam int CHAR_W         = 8;
    localparam int HASH_W         = 8;
    localparam int BUCKET_W       = 7;
    localparam int CHAINS         = 128;
    localparam int CHARS_PER_WORD = 8;
    localparam int NAME_WORD_W    = CHAR_W * CHARS_PER_WORD;
    localparam int INDEX_OUT_W    = 10;
    localparam int COUNT_OUT_W    = 11;

    typedef enum logic {
        ACT_LOOKUP = 1'b0,
        ACT_INSERT = 1'b1
    } t_action;

    typedef struct packed {
        logic              action;
        logic [CHAR_W-1:0] char_code;
        logic              last_char;
    } t_in_word;

    typedef struct packed {
        logic                   found;
        logic [INDEX_OUT_W-1:0] entry_index;
        logic [BUCKET_W-1:0]    bucket;
        logic                   pool_full;
        logic [COUNT_OUT_W-1:0] entry_count;
    } t_out_word;

    // shift left, copy the new top bit into bit 0, fold in the character
    function automatic logic [HASH_W-1:0] hash_step(input logic [HASH_W-1:0] h,
                                                    input logic [CHAR_W-1:0] c);
        logic [HASH_W-1:0] s;
        s    = {h[HASH_W-2:0], 1'b0};
        s[0] = s[HASH_W-1];
        return s ^ c;
    endfunction

endpackage

`default_nettype wire

### rtl/hst_in_if.sv
`default_nettype none

interface hst_in_if import hst_pkg::*; ();
    logic     valid;
    logic     ready;
    t_in_word data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

### rtl/hst_out_if.sv
`default_nettype none

interface hst_out_if import hst_pkg::*; ();
    logic      valid;
    logic      ready;
    t_out_word data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

### rtl/hashed_symbol_table_top.sv
`default_nettype none

// Operation: a non-final character goes into the name buffer. A final character reads
// the chain head (S_HEAD) and decides (S_DECIDE). An insert copies the name word by word
// (S_COPY; 4 words of 8 characters by default); a lookup reads and compares each word
// along the chain (S_RD, S_CMP). An empty chain or a refused insert goes to S_DONE.
// Throughput: one name operation at a time; the input is ready only in the idle state.
// Reset: synchronous; chain heads are marked empty by per-chain valid flags, no sweep.

module hashed_symbol_table_top
    import hst_pkg::*;
#(
    parameter int NAME_CHARS   = 32,
    parameter int POOL_ENTRIES = 1024
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    hst_in_if.sink     i_in,
    hst_out_if.source  o_out
);

    localparam int NW         = (NAME_CHARS + CHARS_PER_WORD - 1) / CHARS_PER_WORD;
    localparam int WSEL_W     = (NW > 1) ? $clog2(NW) : 1;
    localparam int IDX_W      = $clog2(POOL_ENTRIES);
    localparam int LINK_W     = IDX_W + 1;
    localparam int CNT_W      = $clog2(POOL_ENTRIES + 1);
    localparam int NAME_DEPTH = POOL_ENTRIES << WSEL_W;
    localparam int NADDR_W    = IDX_W + WSEL_W;

    typedef enum logic [6:0] {
        S_IDLE   = 7'b0000001,
        S_HEAD   = 7'b0000010,
        S_DECIDE = 7'b0000100,
        S_COPY   = 7'b0001000,
        S_RD     = 7'b0010000,
        S_CMP    = 7'b0100000,
        S_DONE   = 7'b1000000
    } t_state;

    t_state r_state, n_state;

    logic [LINK_W-1:0]      r_heads_mem [CHAINS];
    logic [LINK_W-1:0]      r_links_mem [POOL_ENTRIES];
    logic [NAME_WORD_W-1:0] r_names_mem [NAME_DEPTH];
    logic [CHAINS-1:0]      r_head_vld;

    logic [LINK_W-1:0]      r_head_rd;
    logic                   r_head_rd_vld;
    logic [LINK_W-1:0]      r_link_rd;
    logic [NAME_WORD_W-1:0] r_name_rd;

    logic                   r_action;
    logic [IDX_W-1:0]       r_cur;
    logic [WSEL_W-1:0]      r_word;
    logic [CNT_W-1:0]       r_used;
    logic                   r_res_found;
    logic                   r_res_full;
    logic [IDX_W-1:0]       r_res_index;

    logic                   r_out_valid;
    t_out_word              r_out;

    logic                   in_acc;
    logic                   out_free;
    logic [HASH_W-1:0]      hash;
    logic [BUCKET_W-1:0]    bucket;
    logic [NAME_WORD_W-1:0] buf_word;
    logic [LINK_W-1:0]      head_cur;
    logic                   pool_full;
    logic                   last_word;
    logic                   name_clear;
    logic [IDX_W-1:0]       new_idx;

    assign in_acc     = i_in.valid && i_in.ready;
    assign out_free   = !r_out_valid || o_out.ready;
    assign bucket     = hash[BUCKET_W-1:0];
    assign head_cur   = r_head_rd_vld ? r_head_rd : {1'b1, {IDX_W{1'b0}}};
    assign pool_full  = (r_used == CNT_W'(POOL_ENTRIES));
    assign last_word  = (r_word == WSEL_W'(NW - 1));
    assign name_clear = (r_state == S_DONE) && out_free;
    assign new_idx    = IDX_W'(r_used);

    assign i_in.ready  = (r_state == S_IDLE);
    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_out;

    hst_name_acc #(
        .NAME_CHARS (NAME_CHARS)
    ) u_name_acc (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_push    (in_acc),
        .i_char    (i_in.data.char_code),
        .i_clear   (name_clear),
        .i_rd_word (r_word),
        .o_rd_data (buf_word),
        .o_hash    (hash)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (in_acc && i_in.data.last_char) begin
                    n_state = S_HEAD;
                end
            end
            S_HEAD: begin
                n_state = S_DECIDE;
            end
            S_DECIDE: begin
                if (r_action == ACT_INSERT) begin
                    n_state = pool_full ? S_DONE : S_COPY;
                end else begin
                    n_state = head_cur[IDX_W] ? S_DONE : S_RD;
                end
            end
            S_COPY: begin
                if (last_word) begin
                    n_state = S_DONE;
                end
            end
            S_RD: begin
                n_state = S_CMP;
            end
            S_CMP: begin
                if (r_name_rd == buf_word) begin
                    n_state = last_word ? S_DONE : S_RD;
                end else begin
                    n_state = r_link_rd[IDX_W] ? S_DONE : S_RD;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_head_vld  <= '0;
            r_used      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (name_clear) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
            if (r_state == S_DECIDE && r_action == ACT_INSERT && !pool_full) begin
                r_head_vld[bucket] <= 1'b1;
            end
            if (r_state == S_COPY && last_word) begin
                r_used <= r_used + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc && i_in.data.last_char) begin
            r_action <= i_in.data.action;
        end
        unique case (r_state)
            S_DECIDE: begin
                r_word      <= '0;
                r_cur       <= head_cur[IDX_W-1:0];
                r_res_found <= 1'b0;
                r_res_full  <= (r_action == ACT_INSERT) && pool_full;
                r_res_index <= '0;
            end
            S_COPY: begin
                r_word <= r_word + 1'b1;
                if (last_word) begin
                    r_res_found <= 1'b1;
                    r_res_index <= new_idx;
                end
            end
            S_CMP: begin
                if (r_name_rd == buf_word) begin
                    r_word <= r_word + 1'b1;
                    if (last_word) begin
                        r_res_found <= 1'b1;
                        r_res_index <= r_cur;
                    end
                end else begin
                    r_word <= '0;
                    r_cur  <= r_link_rd[IDX_W-1:0];
                end
            end
            default: begin
            end
        endcase
        if (name_clear) begin
            r_out.found       <= r_res_found;
            r_out.entry_index <= INDEX_OUT_W'(r_res_index);
            r_out.bucket      <= bucket;
            r_out.pool_full   <= r_res_full;
            r_out.entry_count <= COUNT_OUT_W'(r_used);
        end
    end

    // chain heads
    always_ff @(posedge i_clk) begin
        if (r_state == S_HEAD) begin
            r_head_rd     <= r_heads_mem[bucket];
            r_head_rd_vld <= r_head_vld[bucket];
        end
        if (r_state == S_DECIDE && r_action == ACT_INSERT && !pool_full) begin
            r_heads_mem[bucket] <= LINK_W'(new_idx);
        end
    end

    // entry links
    always_ff @(posedge i_clk) begin
        if (r_state == S_RD) begin
            r_link_rd <= r_links_mem[r_cur];
        end
        if (r_state == S_DECIDE && r_action == ACT_INSERT && !pool_full) begin
            r_links_mem[new_idx] <= head_cur;
        end
    end

    // entry names, one word of 8 characters per address
    always_ff @(posedge i_clk) begin
        if (r_state == S_RD) begin
            r_name_rd <= r_names_mem[NADDR_W'({r_cur, r_word})];
        end
        if (r_state == S_COPY) begin
            r_names_mem[NADDR_W'({new_idx, r_word})] <= buf_word;
        end
    end

endmodule

`default_nettype wire

### rtl/hst_name_acc.sv
`default_nettype none

module hst_name_acc
    import hst_pkg::*;
#(
    parameter int NAME_CHARS = 32,
    localparam int NW        = (NAME_CHARS + CHARS_PER_WORD - 1) / CHARS_PER_WORD,
    localparam int WSEL_W    = (NW > 1) ? $clog2(NW) : 1
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_push,
    input  wire logic [CHAR_W-1:0]        i_char,
    input  wire logic                     i_clear,
    input  wire logic [WSEL_W-1:0]        i_rd_word,
    output logic      [NAME_WORD_W-1:0]   o_rd_data,
    output logic      [HASH_W-1:0]        o_hash
);

    localparam int LEN_W  = $clog2(NAME_CHARS + 1);

    logic [NAME_WORD_W-1:0] r_words [NW];
    logic [LEN_W-1:0]       r_len;
    logic [HASH_W-1:0]      r_hash;
    logic                   keep;
    logic [WSEL_W-1:0]      wr_word;
    logic [2:0]             wr_byte;

    assign keep    = i_push && (r_len < LEN_W'(NAME_CHARS));
    assign wr_word = WSEL_W'(r_len >> 3);
    assign wr_byte = 3'(r_len);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clear) begin
            for (int w = 0; w < NW; w++) begin
                r_words[w] <= '0;
            end
            r_len  <= '0;
            r_hash <= '0;
        end else if (keep) begin
            r_words[wr_word][CHAR_W*wr_byte +: CHAR_W] <= i_char;
            r_len  <= r_len + 1'b1;
            r_hash <= hash_step(r_hash, i_char);
        end
    end

    assign o_rd_data = r_words[i_rd_word];
    assign o_hash    = r_hash;

endmodule

`default_nettype wire
